>>> design/ssr_pkg.sv
// shared types and constants of the stream substring replace block
package ssr_pkg;

  localparam int unsigned WordBytes     = 8;
  localparam int unsigned MaxPatternDef = 8;
  localparam int unsigned MaxReplDef    = 8;
  localparam int unsigned CmdDepth      = 2;
  localparam int unsigned AddrW         = 5;
  localparam int unsigned DataW         = 64;

  // register indexes, taken from paddr[4:3]
  localparam logic [1:0] RegPatBytes = 2'd0;
  localparam logic [1:0] RegPatLen   = 2'd1;
  localparam logic [1:0] RegRplBytes = 2'd2;
  localparam logic [1:0] RegRplLen   = 2'd3;

  typedef struct packed {
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [63:0] rpl_bytes;
    logic [3:0]  rpl_len;
  } ssr_cfg_t;

  // one command: up to eight bytes to emit, oldest in bits 7:0
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } ssr_cmd_t;

endpackage

>>> design/ssr_ifs.sv
// stream channel interfaces of the stream substring replace block
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       out_last;

  modport source (output valid, out_byte, byte_present, out_last, input ready);
  modport sink   (input valid, out_byte, byte_present, out_last, output ready);
endinterface

>>> design/ssr_front.sv
// front end: match window, pattern compare and command build
module ssr_front #(
  parameter int unsigned MAX_PATTERN     = ssr_pkg::MaxPatternDef,
  parameter int unsigned MAX_REPLACEMENT = ssr_pkg::MaxReplDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssr_pkg::ssr_cfg_t cfg_i,
  input  logic             clear_i,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             push_o,
  output ssr_pkg::ssr_cmd_t cmd_o
);

  localparam int unsigned WinDepth = (MAX_PATTERN < ssr_pkg::WordBytes) ?
                                     MAX_PATTERN : ssr_pkg::WordBytes;
  localparam int unsigned RplLim   = (MAX_REPLACEMENT < ssr_pkg::WordBytes) ?
                                     MAX_REPLACEMENT : ssr_pkg::WordBytes;
  localparam int unsigned FillW    = $clog2(WinDepth + 1);

  logic [7:0]       win_q [WinDepth];
  logic [7:0]       ins   [WinDepth];
  logic [FillW-1:0] fill_q, fill_d;
  logic [3:0]       plen, rlen, fill4, base, nfill;
  logic             full, hit, shift;

  assign plen  = (cfg_i.pat_len > 4'(WinDepth)) ? 4'(WinDepth) : cfg_i.pat_len;
  assign rlen  = (cfg_i.rpl_len > 4'(RplLim)) ? 4'(RplLim) : cfg_i.rpl_len;
  assign fill4 = 4'(fill_q);
  assign base  = (fill4 >= plen) ? 4'd0 : fill4;
  assign nfill = base + 4'd1;
  assign full  = (nfill == plen);

  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < WinDepth; k++) begin
      ins[k] = (4'(k) == base) ? byte_i : win_q[k];
      if (4'(k) < plen && ins[k] != cfg_i.pat_bytes[8*k +: 8]) hit = 1'b0;
    end
  end

  always_comb begin
    cmd_o.data = '0;
    cmd_o.cnt  = 4'd0;
    cmd_o.last = last_i;
    fill_d     = '0;
    shift      = 1'b0;
    if (plen == 4'd0) begin
      cmd_o.data[7:0] = byte_i;
      cmd_o.cnt       = 4'd1;
    end else if (full && hit) begin
      cmd_o.data = cfg_i.rpl_bytes;
      cmd_o.cnt  = rlen;
    end else if (last_i) begin
      // flush everything left in the window, new byte included
      for (int k = 0; k < WinDepth; k++) cmd_o.data[8*k +: 8] = ins[k];
      cmd_o.cnt = nfill;
    end else if (full) begin
      cmd_o.data[7:0] = ins[0];
      cmd_o.cnt       = 4'd1;
      fill_d          = FillW'(plen - 4'd1);
      shift           = 1'b1;
    end else begin
      fill_d = FillW'(nfill);
    end
  end

  assign push_o = accept_i && (cmd_o.cnt != 4'd0 || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (clear_i) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int k = 0; k < WinDepth; k++) begin
        if (shift && k + 1 < WinDepth) win_q[k] <= ins[(k + 1) % WinDepth];
        else win_q[k] <= ins[k];
      end
    end
  end

endmodule

>>> design/ssr_cmd_fifo.sv
// small command queue between front and back
module ssr_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ssr_pkg::ssr_cmd_t wdata_i,
  input  logic              pop_i,
  output ssr_pkg::ssr_cmd_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (ssr_pkg::CmdDepth > 1) ? $clog2(ssr_pkg::CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(ssr_pkg::CmdDepth + 1);

  ssr_pkg::ssr_cmd_t mem_q [ssr_pkg::CmdDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(ssr_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(ssr_pkg::CmdDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(ssr_pkg::CmdDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

>>> design/ssr_back.sv
// back end: plays out one command a byte per cycle while out_ch is ready
module ssr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssr_pkg::ssr_cmd_t cmd_i,
  input  logic              cmd_avail_i,
  output logic              pop_o,
  ssr_out_if.source         out_ch
);

  logic        busy_q;
  logic [63:0] data_q;
  logic [3:0]  cnt_q;
  logic        last_q;
  logic        fire, done;

  assign out_ch.valid        = busy_q;
  assign out_ch.byte_present = (cnt_q != 4'd0);
  assign out_ch.out_byte     = (cnt_q != 4'd0) ? data_q[7:0] : 8'h00;
  assign out_ch.out_last     = last_q && (cnt_q <= 4'd1);

  assign fire  = busy_q && out_ch.ready;
  assign done  = fire && (cnt_q <= 4'd1);
  assign pop_o = cmd_avail_i && (!busy_q || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.cnt;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= cmd_i.data;
      last_q <= cmd_i.last;
    end else if (fire) begin
      data_q <= {8'h00, data_q[63:8]};
    end
  end

endmodule

>>> design/stream_substring_replace_core.sv
// top level of the stream substring replace block
//
//  channel   dir   handshake            payload
//  in_ch     in    valid / ready        in_byte, in_last
//  out_ch    out   valid / ready        out_byte, byte_present, out_last
//  apb       in    psel/penable/pready  paddr[4:3] selects register, pwdata 64b
//
// one input transaction per cycle is taken while the command queue has room
// a step that yields n bytes (n up to 8) leaves as n output transactions
// input reaches the output through a queue entry, then the back register
// reset clears the window fill, queue pointers, back busy and count, and the config registers
// in_ch and out_ch stall on their own; the two-entry queue parts them
module stream_substring_replace_core #(
  parameter int unsigned MAX_PATTERN     = ssr_pkg::MaxPatternDef,
  parameter int unsigned MAX_REPLACEMENT = ssr_pkg::MaxReplDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ssr_in_if.sink                    in_ch,
  ssr_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssr_pkg::AddrW-1:0] paddr,
  input  logic [ssr_pkg::DataW-1:0] pwdata,
  output logic [ssr_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  ssr_pkg::ssr_cfg_t cfg_q;
  ssr_pkg::ssr_cmd_t cmd_push, cmd_head;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic              accept, push, pop, q_full, q_empty;

  // configuration registers, 8-byte stride
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ssr_pkg::RegPatBytes: cfg_q.pat_bytes <= pwdata;
        ssr_pkg::RegPatLen:   cfg_q.pat_len   <= pwdata[3:0];
        ssr_pkg::RegRplBytes: cfg_q.rpl_bytes <= pwdata;
        ssr_pkg::RegRplLen:   cfg_q.rpl_len   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ssr_pkg::RegPatBytes: prdata = cfg_q.pat_bytes;
      ssr_pkg::RegPatLen:   prdata = {60'd0, cfg_q.pat_len};
      ssr_pkg::RegRplBytes: prdata = cfg_q.rpl_bytes;
      ssr_pkg::RegRplLen:   prdata = {60'd0, cfg_q.rpl_len};
      default:              prdata = '0;
    endcase
  end

  // the front only stalls when the queue is full
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  ssr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .clear_i  (wr_en),      // any register write drops the unresolved window
    .accept_i (accept),
    .byte_i   (in_ch.in_byte),
    .last_i   (in_ch.in_last),
    .push_o   (push),
    .cmd_o    (cmd_push)
  );

  // steps that emit nothing and do not end a string push no command
  ssr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_push),
    .pop_i   (pop),
    .rdata_o (cmd_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ssr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_avail_i (!q_empty),
    .pop_o       (pop),
    .out_ch      (out_ch)
  );

endmodule

>>> design/ssr_checker.sv
// port-level checker for the stream substring replace block, with its bind
module ssr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_present,
  input logic       out_last,
  input logic       pready
);

  logic [7:0] open_q;
  logic       in_end, out_end;

  assign in_end  = in_valid && in_ready && in_last;
  assign out_end = out_valid && out_ready && out_last;

  // strings accepted but not yet closed on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 8'd0;
    end else if (in_end && !out_end) begin
      open_q <= open_q + 8'd1;
    end else if (out_end && !in_end) begin
      open_q <= open_q - 8'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(byte_present) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_present |-> out_last && out_byte == 8'h00)
    else $error("bare end marker without last or with data");

  a_last_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_last |-> open_q != 8'd0)
    else $error("output string end without an input string end");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port not ready");

endmodule

bind stream_substring_replace_core ssr_checker u_ssr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.in_last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .byte_present (out_ch.byte_present),
  .out_last     (out_ch.out_last),
  .pready       (pready)
);
